### src/awsv_pkg.sv
// shared constants, register indexes and the sine table builder for the synth voice
package awsv_pkg;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;
	localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SHAPE     = 3'd5;

	// waveform codes
	localparam logic [1:0] WAVE_SINE   = 2'd0;
	localparam logic [1:0] WAVE_SQUARE = 2'd1;
	localparam logic [1:0] WAVE_SAW    = 2'd2;
	localparam logic [1:0] WAVE_NOISE  = 2'd3;

	// field widths
	localparam int unsigned AMP_W   = 15;
	localparam int unsigned LEN_W   = 24;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned PHASE_W = 32;
	localparam int unsigned OUT_W   = 16;

	// reset values and envelope constants
	localparam logic [AMP_W-1:0]   AMP_RESET  = 15'd16384;
	localparam logic [LEVEL_W-1:0] FULL_LEVEL = 16'h8000;
	localparam logic [31:0]        LFSR_TAPS  = 32'h8020_0003;
	localparam logic [31:0]        LFSR_SEED  = 32'h0000_ACE1;

	// shift-add multiplier and restoring divider both take one bit per cycle
	localparam int unsigned SERIAL_STEPS = 16;
	localparam int unsigned STEP_CNT_W   = 4;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

	// quarter-wave sine entry k, Q0.15, from a Q30 Taylor series in Horner form
	function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned abits);
		logic [63:0] theta;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] v;
		theta = ((64'(k) * 64'd2 + 64'd1) * HALF_PI_Q30) >> (abits + 1);
		x2 = (theta * theta) >> 30;
		t = ONE_Q30 - x2 / 64'd110;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
		t = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
		s = (theta * t) >> 30;
		v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[14:0];
	endfunction

endpackage

### src/adsr_wave_synth_voice.sv
// one synthesizer voice: waveform generator, adsr envelope and bit-serial mul/div
// Usage: one input beat is one sample tick. s_axis_tuser = start_req begins a new
// note and latches phase_step and note_len from s_axis_tdata. Every input beat
// gives exactly one output beat: a signed 16-bit sample on m_axis_tdata, the
// in-note flag on m_axis_tuser and the final-sample flag on m_axis_tlast.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the voice is idle, which the block does not
// enforce. They take effect on the next tick. A tick is worked out one bit per
// cycle in a shared shift-add multiplier and a restoring divider. A tick
// outside a note needs no pass; a sustain sample takes two multiply passes, an
// attack sample one divide and two multiply passes, a decay or release sample
// two multiply passes plus one multiply and one divide pass for the envelope.
// The next beat is taken once the finished beat is in the output register.
// A finished beat sits in the output register: the voice takes the next tick
// while it waits, and stalls only when a second result is ready before the
// first one is taken. Reset clears the note state, restores the register
// defaults and seeds the noise lfsr; there is no clearing pass.
module adsr_wave_synth_voice #(
	parameter int unsigned SINE_ADDR_BITS = 10,
	parameter int unsigned SAMPLE_BITS    = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input tick
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [55:0]                         s_axis_tdata,  // phase_step[31:0], note_len[55:32]
	input  logic                                s_axis_tuser,  // start_req
	// output sample
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [15:0]                         m_axis_tdata,  // sample_out[15:0]
	output logic                                m_axis_tuser,  // active
	output logic                                m_axis_tlast,  // last
	// configuration
	input  logic                                cfg_we,
	input  logic [awsv_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [awsv_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int unsigned SINE_SIZE = 1 << SINE_ADDR_BITS;
	localparam int unsigned PROD_W    = 47;
	localparam int unsigned RND_SH    = 46 - SAMPLE_BITS;
	localparam logic [47:0] RND_HALF  = 48'd1 << (RND_SH - 1);
	localparam logic [47:0] SAMP_LIM  = (48'd1 << (SAMPLE_BITS - 1)) - 48'd1;
	localparam int unsigned SCALE_SHR = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
	localparam int unsigned SCALE_SHL = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
	localparam logic [awsv_pkg::STEP_CNT_W-1:0] STEP_LAST =
		awsv_pkg::STEP_CNT_W'(awsv_pkg::SERIAL_STEPS - 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_EVAL    = 4'd1;
	localparam logic [3:0] ST_WAVE    = 4'd2;
	localparam logic [3:0] ST_MUL_ENV = 4'd3;
	localparam logic [3:0] ST_DIV     = 4'd4;
	localparam logic [3:0] ST_MUL_WA  = 4'd5;
	localparam logic [3:0] ST_MUL_LVL = 4'd6;
	localparam logic [3:0] ST_FIN     = 4'd7;
	localparam logic [3:0] ST_OUT     = 4'd8;

	// configuration registers
	logic [awsv_pkg::AMP_W-1:0]   amp_q;
	logic [awsv_pkg::LEN_W-1:0]   atk_len_q;
	logic [awsv_pkg::LEN_W-1:0]   dec_len_q;
	logic [awsv_pkg::LEVEL_W-1:0] sus_lvl_q;
	logic [awsv_pkg::LEN_W-1:0]   rel_len_q;
	logic [1:0]                   shape_q;

	// voice state
	logic [3:0]                   state_q;
	logic [awsv_pkg::PHASE_W-1:0] phase_q;
	logic [awsv_pkg::PHASE_W-1:0] step_q;
	logic [awsv_pkg::LEN_W-1:0]   idx_q;
	logic [awsv_pkg::LEN_W-1:0]   len_q;
	logic [31:0]                  noise_lfsr_q;
	logic                         playing_q;

	// per-tick working registers
	logic                         neg_q;
	logic [15:0]                  mag_q;
	logic                         is_decay_q;
	logic [awsv_pkg::LEVEL_W-1:0] lvl_q;
	logic [awsv_pkg::STEP_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]            mcand_q;
	logic [15:0]                  mplier_q;
	logic [PROD_W-1:0]            acc_q;
	logic [23:0]                  rem_q;
	logic [15:0]                  num_q;
	logic [15:0]                  quot_q;
	logic [23:0]                  dvs_q;
	logic [15:0]                  res_sample_q;
	logic                         res_act_q;
	logic                         res_last_q;

	// output register
	logic                         out_valid_q;
	logic [15:0]                  out_data_q;
	logic                         out_user_q;
	logic                         out_last_q;

	// sine rom
	logic [14:0]                  sine_rom [SINE_SIZE];
	logic [14:0]                  sine_q;
	logic [SINE_ADDR_BITS-1:0]    sine_addr;

	for (genvar gi = 0; gi < SINE_SIZE; gi++) begin : g_sine
		assign sine_rom[gi] = awsv_pkg::sine_entry(gi, SINE_ADDR_BITS);
	end

	// quadrants 1 and 3 read the table mirrored
	assign sine_addr = phase_q[30] ? ~phase_q[29 -: SINE_ADDR_BITS]
	                               : phase_q[29 -: SINE_ADDR_BITS];

	always_ff @(posedge clk) begin
		sine_q <= sine_rom[sine_addr];
	end

	// combinational helpers
	logic                         in_note;
	logic [31:0]                  lfsr_nxt;
	logic [15:0]                  raw_saw;
	logic [15:0]                  raw_noise;
	logic                         wave_neg;
	logic [15:0]                  wave_mag;
	logic [awsv_pkg::LEVEL_W-1:0] sus_clip;
	logic                         zone_atk;
	logic                         zone_dec;
	logic                         zone_sus;
	logic [24:0]                  ad_sum;
	logic [24:0]                  tr_sum;
	logic [PROD_W-1:0]            acc_nxt;
	logic [24:0]                  div_trial;
	logic                         div_ge;
	logic [23:0]                  div_rem_nxt;
	logic [15:0]                  quot_nxt;
	logic [39:0]                  div_num;
	logic [awsv_pkg::LEVEL_W-1:0] lvl_div;
	logic [awsv_pkg::LEN_W-1:0]   idx_inc;
	logic [47:0]                  m_rnd;
	logic [47:0]                  r_full;
	logic [47:0]                  r_lim;
	logic [47:0]                  r_scaled;
	logic [15:0]                  samp_mag;
	logic                         accept;
	logic                         out_load;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign in_note  = playing_q && (idx_q < len_q);
	assign lfsr_nxt = noise_lfsr_q[0] ? ((noise_lfsr_q >> 1) ^ awsv_pkg::LFSR_TAPS)
	                                  : (noise_lfsr_q >> 1);
	assign raw_saw   = phase_q[31:16];
	assign raw_noise = lfsr_nxt[31:16];

	// finished beat moves into the output register once it is free or being taken
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	always_comb begin
		case (shape_q)
			awsv_pkg::WAVE_SINE: begin
				wave_neg = phase_q[31];
				wave_mag = 16'd0;
			end
			awsv_pkg::WAVE_SQUARE: begin
				wave_neg = phase_q[31];
				wave_mag = 16'd32767;
			end
			awsv_pkg::WAVE_SAW: begin
				wave_neg = !raw_saw[15];
				wave_mag = raw_saw[15] ? {1'b0, raw_saw[14:0]} : (16'h8000 - raw_saw);
			end
			default: begin
				wave_neg = raw_noise[15];
				wave_mag = raw_noise[15] ? (16'd0 - raw_noise) : raw_noise;
			end
		endcase
	end

	// envelope zones, tested in priority order
	assign sus_clip = (sus_lvl_q > awsv_pkg::FULL_LEVEL) ? awsv_pkg::FULL_LEVEL : sus_lvl_q;
	assign ad_sum   = {1'b0, atk_len_q} + {1'b0, dec_len_q};
	assign tr_sum   = {1'b0, idx_q} + {1'b0, rel_len_q};
	assign zone_atk = (atk_len_q != '0) && (idx_q <= atk_len_q);
	assign zone_dec = (dec_len_q != '0) && ({1'b0, idx_q} <= ad_sum);
	assign zone_sus = (tr_sum <= {1'b0, len_q}) || (rel_len_q == '0);

	// one shift-add step
	assign acc_nxt = acc_q + (mplier_q[0] ? mcand_q : '0);

	// one restoring divide step
	assign div_trial   = {rem_q, num_q[15]};
	assign div_ge      = div_trial >= {1'b0, dvs_q};
	assign div_rem_nxt = div_ge ? 24'(div_trial - {1'b0, dvs_q}) : div_trial[23:0];
	assign quot_nxt    = {quot_q[14:0], div_ge};
	assign div_num     = (state_q == ST_WAVE) ? {1'b0, idx_q, 15'd0} : acc_nxt[39:0];
	assign lvl_div     = is_decay_q ? (awsv_pkg::FULL_LEVEL - quot_nxt) : quot_nxt;

	assign idx_inc = idx_q + 1'b1;

	// round half up at SAMPLE_BITS, limit, then scale to 16 bits
	assign m_rnd    = {1'b0, acc_q} + RND_HALF;
	assign r_full   = m_rnd >> RND_SH;
	assign r_lim    = (r_full > SAMP_LIM) ? SAMP_LIM : r_full;
	assign r_scaled = (r_lim >> SCALE_SHR) << SCALE_SHL;
	assign samp_mag = r_scaled[15:0];

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q     <= awsv_pkg::AMP_RESET;
			atk_len_q <= '0;
			dec_len_q <= '0;
			sus_lvl_q <= awsv_pkg::FULL_LEVEL;
			rel_len_q <= '0;
			shape_q   <= awsv_pkg::WAVE_SINE;
		end else if (cfg_we) begin
			case (cfg_index)
				awsv_pkg::REG_AMPLITUDE: amp_q     <= cfg_data[awsv_pkg::AMP_W-1:0];
				awsv_pkg::REG_ATTACK:    atk_len_q <= cfg_data;
				awsv_pkg::REG_DECAY:     dec_len_q <= cfg_data;
				awsv_pkg::REG_SUSTAIN:   sus_lvl_q <= cfg_data[awsv_pkg::LEVEL_W-1:0];
				awsv_pkg::REG_RELEASE:   rel_len_q <= cfg_data;
				awsv_pkg::REG_SHAPE:     shape_q   <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// control and voice state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			phase_q      <= '0;
			step_q       <= '0;
			idx_q        <= '0;
			len_q        <= '0;
			noise_lfsr_q <= awsv_pkg::LFSR_SEED;
			playing_q    <= 1'b0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_axis_tuser) begin
							step_q    <= s_axis_tdata[31:0];
							len_q     <= s_axis_tdata[55:32];
							phase_q   <= '0;
							idx_q     <= '0;
							playing_q <= 1'b1;
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (in_note) begin
						if (shape_q == awsv_pkg::WAVE_NOISE) begin
							noise_lfsr_q <= lfsr_nxt;
						end
						state_q <= ST_WAVE;
					end else begin
						playing_q <= 1'b0;
						state_q   <= ST_OUT;
					end
				end
				ST_WAVE: begin
					cnt_q <= '0;
					if (zone_atk) begin
						state_q <= ST_DIV;
					end else if (zone_dec || !zone_sus) begin
						state_q <= ST_MUL_ENV;
					end else begin
						state_q <= ST_MUL_WA;
					end
				end
				ST_MUL_ENV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_LAST) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_LAST) begin
						state_q <= ST_MUL_WA;
					end
				end
				ST_MUL_WA: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_LAST) begin
						state_q <= ST_MUL_LVL;
					end
				end
				ST_MUL_LVL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == STEP_LAST) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					phase_q <= phase_q + step_q;
					idx_q   <= idx_inc;
					if (idx_inc >= len_q) begin
						playing_q <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_EVAL: begin
				neg_q        <= wave_neg;
				mag_q        <= wave_mag;
				res_sample_q <= '0;
				res_act_q    <= 1'b0;
				res_last_q   <= 1'b0;
			end
			ST_WAVE: begin
				is_decay_q <= !zone_atk && zone_dec;
				if (shape_q == awsv_pkg::WAVE_SINE) begin
					mag_q <= {1'b0, sine_q};
				end
				acc_q <= '0;
				if (zone_atk) begin
					rem_q  <= div_num[39:16];
					num_q  <= div_num[15:0];
					quot_q <= '0;
					dvs_q  <= atk_len_q;
				end else if (zone_dec) begin
					mcand_q  <= PROD_W'(idx_q - atk_len_q);
					mplier_q <= awsv_pkg::FULL_LEVEL - sus_clip;
					dvs_q    <= dec_len_q;
				end else if (!zone_sus) begin
					mcand_q  <= PROD_W'(len_q - idx_q);
					mplier_q <= sus_clip;
					dvs_q    <= rel_len_q;
				end else begin
					lvl_q    <= sus_clip;
					mcand_q  <= PROD_W'((shape_q == awsv_pkg::WAVE_SINE) ? {1'b0, sine_q} : mag_q);
					mplier_q <= {1'b0, amp_q};
				end
			end
			ST_MUL_ENV: begin
				acc_q    <= acc_nxt;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				if (cnt_q == STEP_LAST) begin
					rem_q  <= div_num[39:16];
					num_q  <= div_num[15:0];
					quot_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q  <= div_rem_nxt;
				num_q  <= num_q << 1;
				quot_q <= quot_nxt;
				if (cnt_q == STEP_LAST) begin
					lvl_q    <= lvl_div;
					acc_q    <= '0;
					mcand_q  <= PROD_W'(mag_q);
					mplier_q <= {1'b0, amp_q};
				end
			end
			ST_MUL_WA: begin
				if (cnt_q == STEP_LAST) begin
					acc_q    <= '0;
					mcand_q  <= PROD_W'(acc_nxt[30:0]);
					mplier_q <= lvl_q;
				end else begin
					acc_q    <= acc_nxt;
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
				end
			end
			ST_MUL_LVL: begin
				acc_q    <= acc_nxt;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			ST_FIN: begin
				res_sample_q <= neg_q ? (16'd0 - samp_mag) : samp_mag;
				res_act_q    <= 1'b1;
				res_last_q   <= (idx_inc == len_q);
			end
			ST_OUT: begin
				if (out_load) begin
					out_data_q <= res_sample_q;
					out_user_q <= res_act_q;
					out_last_q <= res_last_q;
				end
			end
			default: ;
		endcase
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

	// divider partial remainder always stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

	// envelope level never exceeds full scale
	a_lvl_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL_LVL) |-> (lvl_q <= awsv_pkg::FULL_LEVEL))
		else $error("envelope level above full scale");

	// a beat outside a note carries silence
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
		else $error("nonzero sample outside a note");

	// the final sample of a note is an in-note sample
	a_last_act: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
		else $error("last flag without active flag");

	// the note ends together with its final sample
	a_note_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && idx_inc == len_q) |=> !playing_q)
		else $error("voice still playing after final sample");

	// galois lfsr never locks up at zero
	a_lfsr_live: assert property (@(posedge clk) disable iff (!arst_n)
		noise_lfsr_q != '0)
		else $error("noise lfsr reached zero");

endmodule
